/* hdl/bnp_pkg.sv */
package bnp_pkg;

    // Default tree size and stored key width
    localparam int NODE_COUNT_DEF = 16;
    localparam int KEY_BITS_DEF   = 32;

    // Fixed port widths
    localparam int KEY_PORT_W = 32;
    localparam int STATUS_W   = 3;
    localparam int SLOT_W     = 4;

    // Request operation
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } t_op;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED = 3'd0,
        STAT_PRESENT  = 3'd1,
        STAT_FULL     = 3'd2,
        STAT_DELETED  = 3'd3,
        STAT_MISSING  = 3'd4
    } t_status;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DESC,
        ST_MISS,
        ST_FILL,
        ST_HIT,
        ST_PRED,
        ST_KEYW,
        ST_LINK,
        ST_FREE,
        ST_DONE
    } t_state;

    // Per-field write enables of the node memory
    typedef struct packed {
        logic key;
        logic left;
        logic right;
    } t_ram_we;

endpackage

/* hdl/bnp_node_ram.sv */
module bnp_node_ram import bnp_pkg::*; #(
    parameter int NODE_COUNT = NODE_COUNT_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic [$clog2(NODE_COUNT)-1:0]       i_rd_addr,
    output logic signed [KEY_BITS-1:0]          o_rd_key,
    output logic [$clog2(NODE_COUNT+1)-1:0]     o_rd_left,
    output logic [$clog2(NODE_COUNT+1)-1:0]     o_rd_right,
    input  t_ram_we                             i_we,
    input  logic [$clog2(NODE_COUNT)-1:0]       i_wr_addr,
    input  logic signed [KEY_BITS-1:0]          i_wr_key,
    input  logic [$clog2(NODE_COUNT+1)-1:0]     i_wr_left,
    input  logic [$clog2(NODE_COUNT+1)-1:0]     i_wr_right
);

    localparam int LINK_W = $clog2(NODE_COUNT + 1);

    logic signed [KEY_BITS-1:0] r_key_mem   [NODE_COUNT];
    logic [LINK_W-1:0]          r_left_mem  [NODE_COUNT];
    logic [LINK_W-1:0]          r_right_mem [NODE_COUNT];

    // Write the selected fields of one node
    always_ff @(posedge i_clk) begin
        if (i_we.key) begin
            r_key_mem[i_wr_addr] <= i_wr_key;
        end
        if (i_we.left) begin
            r_left_mem[i_wr_addr] <= i_wr_left;
        end
        if (i_we.right) begin
            r_right_mem[i_wr_addr] <= i_wr_right;
        end
    end

    // Read one node, registered
    always_ff @(posedge i_clk) begin
        o_rd_key   <= r_key_mem[i_rd_addr];
        o_rd_left  <= r_left_mem[i_rd_addr];
        o_rd_right <= r_right_mem[i_rd_addr];
    end

endmodule

/* hdl/bnp_key_cmp.sv */
module bnp_key_cmp import bnp_pkg::*; #(
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic signed [KEY_BITS-1:0] i_a,
    input  logic signed [KEY_BITS-1:0] i_b,
    output logic                       o_eq,
    output logic                       o_lt
);

    // Signed order of the request key against a node key
    assign o_eq = (i_a == i_b);
    assign o_lt = (i_a < i_b);

endmodule

/* hdl/bst_node_pool_insert_delete.sv */
// Binary search tree of signed keys in a pool of NODE_COUNT nodes held in one
// node memory (key, left link, right link) with one registered read port and one
// write port, with unused nodes on a free list chained through the right links.
// Each request inserts or deletes one key and yields exactly one result (status
// and node slot). After reset a clearing pass over all NODE_COUNT nodes builds the
// free list; no request is taken until it ends. A request is then taken, walks
// down the tree one node at a time, walks right to the in-order predecessor on a
// two-child delete, and ends with a decision, any link writes and the result
// load. The node memory serves one node read per cycle and is walked by a small
// sequencer around one shared key comparator. A finished result waits in an
// output register, and the next request is taken while it waits; a request that
// finishes while that register is still full stalls until the result is taken.
module bst_node_pool_insert_delete import bnp_pkg::*; #(
    parameter int NODE_COUNT = NODE_COUNT_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_operation,
    input  logic signed [KEY_PORT_W-1:0] i_key,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [STATUS_W-1:0]          o_status,
    output logic [SLOT_W-1:0]            o_slot
);

    localparam int LINK_W = $clog2(NODE_COUNT + 1);
    localparam int IDX_W  = $clog2(NODE_COUNT);

    typedef logic [LINK_W-1:0]          t_link;
    typedef logic [IDX_W-1:0]           t_idx;
    typedef logic signed [KEY_BITS-1:0] t_key;

    localparam t_link NIL  = LINK_W'(NODE_COUNT);
    localparam t_link LAST = LINK_W'(NODE_COUNT - 1);

    // Map any out-of-range link to the null marker
    function automatic t_link f_norm(input t_link link);
        return (link < NIL) ? link : NIL;
    endfunction

    t_state  r_state, n_state;
    t_op     r_op, n_op;
    t_key    r_key, n_key;
    t_key    r_pkey, n_pkey;
    t_link   r_cur, n_cur;
    t_link   r_parent, n_parent;
    logic    r_side, n_side;
    t_link   r_iter, n_iter;
    t_link   r_l, n_l;
    t_link   r_r, n_r;
    t_link   r_slot, n_slot;
    t_link   r_lval, n_lval;
    t_status r_status, n_status;
    t_link   r_free_head, n_free_head;
    t_link   r_root, n_root;
    logic    r_out_valid, n_out_valid;
    t_status r_out_status, n_out_status;
    t_link   r_out_slot, n_out_slot;

    t_idx    rd_addr;
    t_key    rd_key;
    t_link   rd_left;
    t_link   rd_right;
    t_ram_we we;
    t_idx    wr_addr;
    t_key    wr_key;
    t_link   wr_left;
    t_link   wr_right;
    logic    cmp_eq;
    logic    cmp_lt;
    t_link   root_n;
    t_link   free_n;
    t_link   desc_next;
    t_link   pred_next;

    bnp_node_ram #(
        .NODE_COUNT (NODE_COUNT),
        .KEY_BITS   (KEY_BITS)
    ) u_ram (
        .i_clk      (i_clk),
        .i_rd_addr  (rd_addr),
        .o_rd_key   (rd_key),
        .o_rd_left  (rd_left),
        .o_rd_right (rd_right),
        .i_we       (we),
        .i_wr_addr  (wr_addr),
        .i_wr_key   (wr_key),
        .i_wr_left  (wr_left),
        .i_wr_right (wr_right)
    );

    bnp_key_cmp #(
        .KEY_BITS (KEY_BITS)
    ) u_cmp (
        .i_a  (r_key),
        .i_b  (rd_key),
        .o_eq (cmp_eq),
        .o_lt (cmp_lt)
    );

    assign root_n    = f_norm(r_root);
    assign free_n    = f_norm(r_free_head);
    assign desc_next = f_norm(cmp_lt ? rd_left : rd_right);
    assign pred_next = f_norm(rd_right);

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_slot      = SLOT_W'(r_out_slot);

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_iter      <= '0;
            r_free_head <= '0;
            r_root      <= NIL;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_iter      <= n_iter;
            r_free_head <= n_free_head;
            r_root      <= n_root;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold working and result payload
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_pkey       <= n_pkey;
        r_cur        <= n_cur;
        r_parent     <= n_parent;
        r_side       <= n_side;
        r_l          <= n_l;
        r_r          <= n_r;
        r_slot       <= n_slot;
        r_lval       <= n_lval;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
    end

    // Sequence one request over the node memory
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_key        = r_key;
        n_pkey       = r_pkey;
        n_cur        = r_cur;
        n_parent     = r_parent;
        n_side       = r_side;
        n_iter       = r_iter;
        n_l          = r_l;
        n_r          = r_r;
        n_slot       = r_slot;
        n_lval       = r_lval;
        n_status     = r_status;
        n_free_head  = r_free_head;
        n_root       = r_root;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        rd_addr      = '0;
        we           = '0;
        wr_addr      = '0;
        wr_key       = r_key;
        wr_left      = NIL;
        wr_right     = NIL;

        // Drop the result once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            // Build the free list, one node per cycle
            ST_CLEAR: begin
                we.left  = 1'b1;
                we.right = 1'b1;
                wr_addr  = r_iter[IDX_W-1:0];
                wr_right = (r_iter == LAST) ? NIL : LINK_W'(r_iter + 1'b1);
                if (r_iter == LAST) begin
                    n_iter  = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_iter = LINK_W'(r_iter + 1'b1);
                end
            end

            // Take a request and start at the root
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_op     = t_op'(i_operation);
                    n_key    = KEY_BITS'(i_key);
                    n_parent = NIL;
                    n_side   = 1'b0;
                    n_iter   = '0;
                    n_cur    = root_n;
                    if (root_n == NIL) begin
                        n_state = ST_MISS;
                    end else begin
                        rd_addr = root_n[IDX_W-1:0];
                        n_state = ST_DESC;
                    end
                end
            end

            // Compare against the current node and step down
            ST_DESC: begin
                if (cmp_eq) begin
                    n_l     = f_norm(rd_left);
                    n_r     = f_norm(rd_right);
                    n_state = ST_HIT;
                end else if (r_iter == NIL) begin
                    n_state = ST_MISS;
                end else begin
                    n_parent = r_cur;
                    n_side   = ~cmp_lt;
                    n_cur    = desc_next;
                    n_iter   = LINK_W'(r_iter + 1'b1);
                    if (desc_next == NIL) begin
                        n_state = ST_MISS;
                    end else begin
                        rd_addr = desc_next[IDX_W-1:0];
                    end
                end
            end

            // Key absent: report, or fetch the free-list head
            ST_MISS: begin
                if (r_op == OP_DELETE) begin
                    n_status = STAT_MISSING;
                    n_slot   = '0;
                    n_state  = ST_DONE;
                end else if (free_n == NIL) begin
                    n_status = STAT_FULL;
                    n_slot   = '0;
                    n_state  = ST_DONE;
                end else begin
                    rd_addr = free_n[IDX_W-1:0];
                    n_slot  = free_n;
                    n_state = ST_FILL;
                end
            end

            // Pop the free node and write it as a new leaf
            ST_FILL: begin
                n_free_head = f_norm(rd_right);
                we          = '{key: 1'b1, left: 1'b1, right: 1'b1};
                wr_addr     = r_slot[IDX_W-1:0];
                wr_key      = r_key;
                n_lval      = r_slot;
                n_status    = STAT_INSERTED;
                n_state     = ST_LINK;
            end

            // Key present: report, or pick the delete case
            ST_HIT: begin
                if (r_op == OP_INSERT) begin
                    n_status = STAT_PRESENT;
                    n_slot   = '0;
                    n_state  = ST_DONE;
                end else begin
                    n_status = STAT_DELETED;
                    if (r_l != NIL && r_r != NIL) begin
                        n_parent = r_cur;
                        n_side   = 1'b0;
                        n_slot   = r_l;
                        n_iter   = '0;
                        rd_addr  = r_l[IDX_W-1:0];
                        n_state  = ST_PRED;
                    end else begin
                        n_lval  = (r_l != NIL) ? r_l : r_r;
                        n_slot  = r_cur;
                        n_state = ST_LINK;
                    end
                end
            end

            // Walk right to the in-order predecessor
            ST_PRED: begin
                if (pred_next == NIL || r_iter == NIL) begin
                    n_pkey  = rd_key;
                    n_lval  = f_norm(rd_left);
                    n_state = ST_KEYW;
                end else begin
                    n_parent = r_slot;
                    n_side   = 1'b1;
                    n_slot   = pred_next;
                    n_iter   = LINK_W'(r_iter + 1'b1);
                    rd_addr  = pred_next[IDX_W-1:0];
                end
            end

            // Move the predecessor key into the deleted node
            ST_KEYW: begin
                we.key  = 1'b1;
                wr_addr = r_cur[IDX_W-1:0];
                wr_key  = r_pkey;
                n_state = ST_LINK;
            end

            // Rewrite the parent link (or the root)
            ST_LINK: begin
                if (r_parent == NIL) begin
                    n_root = r_lval;
                end else begin
                    wr_addr = r_parent[IDX_W-1:0];
                    if (r_side) begin
                        we.right = 1'b1;
                        wr_right = r_lval;
                    end else begin
                        we.left = 1'b1;
                        wr_left = r_lval;
                    end
                end
                n_state = (r_op == OP_DELETE) ? ST_FREE : ST_DONE;
            end

            // Push the removed node on the free list
            ST_FREE: begin
                we.left     = 1'b1;
                we.right    = 1'b1;
                wr_addr     = r_slot[IDX_W-1:0];
                wr_left     = NIL;
                wr_right    = free_n;
                n_free_head = r_slot;
                n_state     = ST_DONE;
            end

            // Load the result once the output register is free
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_slot   = r_slot;
                    n_state      = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
